/* hdl/armr_pkg.sv */
// package for the audio resample mix ring
// shared widths, reset values, op codes, register indexes and sequencer states
// no dependencies
package armr_pkg;

   // default storage and rate parameters
   localparam int RING_DEPTH_DEF  = 8192;
   localparam int SOURCE_RATE_DEF = 31440;

   // field widths
   localparam int OP_W       = 2;
   localparam int SAMPLE_W   = 8;
   localparam int RATE_W     = 17;
   localparam int DIVR_W     = 16;
   localparam int PHASE_W    = 18;
   localparam int CNT_W      = 17;
   localparam int DIV_CNT_W  = $clog2(RATE_W);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // register reset values
   localparam logic [RATE_W-1:0] OUT_RATE_RST   = RATE_W'(44100);
   localparam logic [DIVR_W-1:0] FRAME_DIV_RST  = DIVR_W'(60);
   localparam logic [DIVR_W-1:0] ROUND_UNIT_RST = DIVR_W'(60);
   localparam logic              MIX_EN_RST     = 1'b0;

   // request op codes
   localparam logic [OP_W-1:0] OP_FRAME  = 2'd0;
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_DIV  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_UNIT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_EN     = 2'd3;

   // sequencer states
   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_DIV    = 7'b0000100,
      ST_ROUND  = 7'b0001000,
      ST_SAMPLE = 7'b0010000,
      ST_ADD    = 7'b0100000,
      ST_READ   = 7'b1000000
   } state_type;

endpackage

/* hdl/armr_ifs.sv */
// valid/ready channel interfaces for the audio resample mix ring
// request, response and register write channels; uses armr_pkg
interface armr_req_if
   import armr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [SAMPLE_W-1:0] primary_sample;
   logic [SAMPLE_W-1:0] secondary_sample;

   modport source (output valid, output op, output primary_sample,
                   output secondary_sample, input ready);
   modport sink   (input valid, input op, input primary_sample,
                   input secondary_sample, output ready);
endinterface

interface armr_rsp_if
   import armr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface

interface armr_csr_if
   import armr_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/audio_resample_mix_ring.sv */
// top level of the audio resample mix ring
// sequencer, shared add/subtract unit and byte ring; uses armr_pkg and armr_ifs
//
// Resamples 8-bit sound chip samples from SOURCE_RATE to out_rate with a phase
// accumulator and stores them in a byte ring of RING_DEPTH entries; a read
// request returns one ring byte and clears it. After reset the block sweeps the
// ring to zero (RING_DEPTH entries, 8192 by default) and takes no request until
// the sweep is done; register writes are taken at any time. One 18-bit
// add/subtract unit does all the arithmetic under the sequencer, so items are
// handled one at a time. A frame start runs 17 restoring divide steps and then
// one rounding step, or ends at its accept when the frame divisor is zero. A
// source sample writes its ring bytes in turn and then adds out_rate to the
// phase, unless the frame is complete. A read fetches the ring byte and then
// waits for the previous response to be taken. Reserved op code 3 is ignored.
module audio_resample_mix_ring
   import armr_pkg::*;
#(
   parameter int RING_DEPTH  = RING_DEPTH_DEF,
   parameter int SOURCE_RATE = SOURCE_RATE_DEF
) (
   input logic         clock,
   input logic         reset,
   armr_req_if.sink    req_ch,
   armr_rsp_if.source  rsp_ch,
   armr_csr_if.sink    csr_ch
);

   localparam int                 PTR_W    = $clog2(RING_DEPTH);
   localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(RING_DEPTH - 1);
   localparam logic [PHASE_W-1:0] SRC_STEP = PHASE_W'(SOURCE_RATE);

   // configuration registers
   logic [RATE_W-1:0] out_rate_ff;
   logic [DIVR_W-1:0] frame_div_ff;
   logic [DIVR_W-1:0] round_unit_ff;
   logic              mix_en_ff;

   // sequencer and datapath state
   state_type            state_ff, state_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [CNT_W-1:0]     length_ff, length_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [DIVR_W-1:0]    div_rem_ff, div_rem_in;
   logic [RATE_W-1:0]    div_quo_ff, div_quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  rsp_data_ff, rsp_data_in;

   // ring memory and its ports
   logic [SAMPLE_W-1:0]  ring_mem [RING_DEPTH];
   logic [SAMPLE_W-1:0]  rd_data_ff;
   logic                 mem_we;
   logic [PTR_W-1:0]     mem_waddr;
   logic [SAMPLE_W-1:0]  mem_wdata;
   logic                 mem_re;

   // shared add/subtract unit
   logic [PHASE_W-1:0]   alu_a;
   logic [PHASE_W-1:0]   alu_b;
   logic                 alu_sub;
   logic [PHASE_W:0]     alu_sum;
   logic [PHASE_W-1:0]   alu_res;
   logic                 alu_ge;

   logic                 req_xfer;
   logic                 count_lt;
   logic [SAMPLE_W:0]    mix_sum;
   logic [DIVR_W-1:0]    div_trial;

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign req_xfer         = req_ch.valid && req_ch.ready;
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_data = rsp_data_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         out_rate_ff   <= OUT_RATE_RST;
         frame_div_ff  <= FRAME_DIV_RST;
         round_unit_ff <= ROUND_UNIT_RST;
         mix_en_ff     <= MIX_EN_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_OUT_RATE:   out_rate_ff   <= csr_ch.data[RATE_W-1:0];
            CSR_FRAME_DIV:  frame_div_ff  <= csr_ch.data[DIVR_W-1:0];
            CSR_ROUND_UNIT: round_unit_ff <= csr_ch.data[DIVR_W-1:0];
            CSR_MIX_EN:     mix_en_ff     <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // operand select for the shared unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b1;
      case (state_ff)
         ST_DIV: begin
            alu_a = PHASE_W'({div_rem_ff, div_quo_ff[RATE_W-1]});
            alu_b = PHASE_W'(frame_div_ff);
         end
         ST_ROUND: begin
            alu_a = PHASE_W'(div_rem_ff);
            alu_b = PHASE_W'(round_unit_ff);
         end
         ST_SAMPLE: begin
            alu_a = phase_ff;
            alu_b = SRC_STEP;
         end
         ST_ADD: begin
            alu_a   = phase_ff;
            alu_b   = PHASE_W'(out_rate_ff);
            alu_sub = 1'b0;
         end
         default: ;
      endcase
   end

   // carry out of a subtraction means a >= b
   assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                  + (PHASE_W+1)'(alu_sub);
   assign alu_res = alu_sum[PHASE_W-1:0];
   assign alu_ge  = alu_sum[PHASE_W];

   assign count_lt  = (count_ff < length_ff);
   assign mix_sum   = {1'b0, req_ch.primary_sample} + {1'b0, req_ch.secondary_sample};
   assign div_trial = {div_rem_ff[DIVR_W-2:0], div_quo_ff[RATE_W-1]};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      sample_in    = sample_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      mem_we       = 1'b0;
      mem_waddr    = wr_ptr_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      case (state_ff)
         // sweep the ring to zero after reset
         ST_CLEAR: begin
            mem_we    = 1'b1;
            wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
            if (wr_ptr_ff == PTR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_ch.op)
                  OP_FRAME: begin
                     phase_in = PHASE_W'(out_rate_ff);
                     count_in = '0;
                     if (frame_div_ff == '0) begin
                        length_in = '0;
                     end else begin
                        div_rem_in = '0;
                        div_quo_in = out_rate_ff;
                        div_cnt_in = '0;
                        state_in   = ST_DIV;
                     end
                  end
                  OP_SAMPLE: begin
                     sample_in = mix_en_ff ? mix_sum[SAMPLE_W:1] : req_ch.primary_sample;
                     state_in  = ST_SAMPLE;
                  end
                  OP_READ: begin
                     mem_re   = 1'b1;
                     state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         // one restoring divide step per cycle, quotient shifts in at the bottom
         ST_DIV: begin
            div_rem_in = alu_ge ? alu_res[DIVR_W-1:0] : div_trial;
            div_quo_in = {div_quo_ff[RATE_W-2:0], alu_ge};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(RATE_W - 1)) begin
               state_in = ST_ROUND;
            end
         end
         // round up when the remainder is nonzero and reaches the unit
         ST_ROUND: begin
            length_in = (div_rem_ff != '0 && alu_ge) ? div_quo_ff + CNT_W'(1)
                                                      : div_quo_ff;
            state_in  = ST_IDLE;
         end
         // one ring write per cycle while the phase covers a source period and the frame is not complete
         ST_SAMPLE: begin
            if (alu_ge && count_lt) begin
               mem_we    = 1'b1;
               mem_wdata = sample_ff;
               wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
               phase_in  = alu_res;
               count_in  = count_ff + CNT_W'(1);
            end else if (count_lt) begin
               state_in = ST_ADD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ADD: begin
            phase_in = alu_res;
            state_in = ST_IDLE;
         end
         // hand the byte to the output register and clear the entry
         ST_READ: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_data_in  = rd_data_ff;
               rsp_valid_in = 1'b1;
               mem_we       = 1'b1;
               mem_waddr    = rd_ptr_ff;
               rd_ptr_in    = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= '0;
         length_ff    <= '0;
         count_ff     <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // byte ring
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= ring_mem[rd_ptr_ff];
      end
   end

endmodule

/* hdl/armr_checker.sv */
// port checker for the audio resample mix ring, bound to the top level
// watches the request and response channels; uses armr_pkg
module armr_checker
   import armr_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [OP_W-1:0]     req_op,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SAMPLE_W-1:0] rsp_read_data
);

   // response held until transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_read_data))
      else $error("response data changed while stalled");

   // ring clearing keeps requests out after reset
   a_clear_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during ring clear");

   // a source sample always occupies the sequencer past its accept cycle
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_SAMPLE |=> !req_ready)
      else $error("ready right after source sample");

   // a read goes through the memory before the next request
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_READ |=> !req_ready)
      else $error("ready right after read request");

endmodule

bind audio_resample_mix_ring armr_checker u_armr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_op        (req_ch.op),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_read_data (rsp_ch.read_data)
);
